>>> design/tilt_limited_drive_controller_defines.svh
// assertion macros shared by the tilt drive controller rtl
`ifndef TILT_LIMITED_DRIVE_CONTROLLER_DEFINES_SVH
`define TILT_LIMITED_DRIVE_CONTROLLER_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define TLDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tldc assertion failed");

// next-cycle implication, quiet while in reset
`define TLDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tldc assertion failed");

`endif

>>> design/tldc_pkg.sv
`default_nettype none

package tldc_pkg;

    localparam int SAMPLE_W         = 12;
    localparam int TILT_W           = 13;
    localparam int WINDOW_DEPTH_DEF = 16;

    localparam logic signed [TILT_W-1:0] OPEN_LIMIT_RST  = 13'sd600;
    localparam logic signed [TILT_W-1:0] CLOSE_LIMIT_RST = 13'sd980;

    typedef enum logic [1:0] {
        KIND_PRELOAD = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_COMMAND = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ACT_DONE  = 2'd0,
        ACT_OPEN  = 2'd1,
        ACT_CLOSE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        DIR_STOP  = 2'd0,
        DIR_OPEN  = 2'd1,
        DIR_CLOSE = 2'd2
    } t_dir;

    typedef enum logic {
        CFG_OPEN_LIMIT  = 1'b0,
        CFG_CLOSE_LIMIT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [1:0]                 kind;
        logic signed [SAMPLE_W-1:0] tilt_sample;
        logic [1:0]                 command_code;
    } t_in_item;

    typedef struct packed {
        logic signed [TILT_W-1:0] smoothed_tilt;
        logic [1:0]               drive_direction;
        logic                     drive_power;
        logic [1:0]               current_command;
    } t_out_item;

    typedef struct packed {
        t_cmd cmd;
        t_dir dir;
        logic pwr;
    } t_drive;

endpackage

`default_nettype wire

>>> design/tldc_filter.sv
`default_nettype none

module tldc_filter
    import tldc_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    output logic signed [TILT_W-1:0]        o_total
);

    localparam int DEPTH_LOG = $clog2(WINDOW_DEPTH);
    localparam int MAG_W     = SAMPLE_W;
    localparam int DIV_SHIFT = MAG_W + DEPTH_LOG;
    localparam int RECIP_W   = MAG_W + 2;
    localparam int PROD_W    = DIV_SHIFT + MAG_W;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

    logic signed [TILT_W-1:0] r_hist [WINDOW_DEPTH];
    logic signed [TILT_W-1:0] r_total;
    logic signed [TILT_W-1:0] n_total;

    logic signed [TILT_W-1:0] neg_x;
    logic                     neg_sign;
    logic [MAG_W-1:0]         mag;
    logic [PROD_W-1:0]        prod;
    logic [MAG_W-1:0]         q_mag;
    logic signed [TILT_W-1:0] quot;

    // negate, then divide by the window depth truncating toward zero
    always_comb begin
        neg_x    = TILT_W'(0) - {i_sample[SAMPLE_W-1], i_sample};
        neg_sign = neg_x[TILT_W-1];
        mag      = neg_sign ? MAG_W'(TILT_W'(0) - neg_x) : neg_x[MAG_W-1:0];
        prod     = PROD_W'(mag) * PROD_W'(DIV_RECIP);
        q_mag    = prod[DIV_SHIFT +: MAG_W];
        quot     = neg_sign ? (TILT_W'(0) - {1'b0, q_mag}) : {1'b0, q_mag};
    end

    always_comb begin
        if (i_push) begin
            n_total = r_total - r_hist[WINDOW_DEPTH-1] + quot;
        end else begin
            n_total = r_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_push) begin
            r_total   <= n_total;
            r_hist[0] <= quot;
            for (int i = 1; i < WINDOW_DEPTH; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    assign o_total = n_total;

endmodule

`default_nettype wire

>>> design/tldc_ctrl.sv
`default_nettype none
`include "tilt_limited_drive_controller_defines.svh"

module tldc_ctrl
    import tldc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_fire,
    input  wire t_in_item                 i_item,
    input  wire logic                     i_cfg_we,
    input  wire logic                     i_cfg_index,
    input  wire logic [TILT_W-1:0]        i_cfg_data,
    input  wire logic signed [TILT_W-1:0] i_total,
    output logic                          o_push,
    output t_drive                        o_next
);

    t_cmd r_cmd;
    t_cmd n_cmd;
    t_dir r_dir;
    t_dir n_dir;
    logic r_pwr;
    logic n_pwr;
    logic signed [TILT_W-1:0] r_open_limit;
    logic signed [TILT_W-1:0] r_close_limit;

    logic open_go;
    logic close_go;

    logic       tick_fire;
    logic       cmd_fire;
    logic       done_tick;
    logic       drive_off;
    logic [2:0] cur_drive;

    assign open_go  = i_total > r_open_limit;
    assign close_go = i_total < r_close_limit;

    assign tick_fire = i_fire && (i_item.kind == KIND_TICK);
    assign cmd_fire  = i_fire && (i_item.kind == KIND_COMMAND);
    assign done_tick = tick_fire && (r_cmd == ACT_DONE);
    assign drive_off = !r_pwr && (r_dir == DIR_STOP);
    assign cur_drive = {r_pwr, r_dir};

    // next command
    always_comb begin
        n_cmd = r_cmd;
        if (i_fire) begin
            case (i_item.kind)
                KIND_TICK: begin
                    case (r_cmd)
                        ACT_OPEN:  if (!open_go) n_cmd = ACT_DONE;
                        ACT_CLOSE: if (!close_go) n_cmd = ACT_DONE;
                        default: ;
                    endcase
                end
                KIND_COMMAND: begin
                    if (i_item.command_code inside {ACT_DONE, ACT_OPEN, ACT_CLOSE}) begin
                        n_cmd = t_cmd'(i_item.command_code);
                    end
                end
                default: ;
            endcase
        end
    end

    // sampling
    always_comb begin
        o_push = 1'b0;
        if (i_fire) begin
            case (i_item.kind)
                KIND_PRELOAD: o_push = 1'b1;
                KIND_TICK:    o_push = (r_cmd == ACT_OPEN) || (r_cmd == ACT_CLOSE);
                default: ;
            endcase
        end
    end

    // motor drive
    always_comb begin
        n_dir  = r_dir;
        n_pwr  = r_pwr;
        if (i_fire) begin
            case (i_item.kind)
                KIND_TICK: begin
                    case (r_cmd)
                        ACT_OPEN: begin
                            if (open_go) begin
                                n_dir = DIR_OPEN;
                                n_pwr = 1'b1;
                            end
                        end
                        ACT_CLOSE: begin
                            if (close_go) begin
                                n_dir = DIR_CLOSE;
                                n_pwr = 1'b1;
                            end
                        end
                        default: begin
                            n_dir = DIR_STOP;
                            n_pwr = 1'b0;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= ACT_DONE;
            r_dir <= DIR_STOP;
            r_pwr <= 1'b0;
        end else begin
            r_cmd <= n_cmd;
            r_dir <= n_dir;
            r_pwr <= n_pwr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_limit  <= OPEN_LIMIT_RST;
            r_close_limit <= CLOSE_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_OPEN_LIMIT:  r_open_limit  <= i_cfg_data;
                CFG_CLOSE_LIMIT: r_close_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_next.cmd = n_cmd;
    assign o_next.dir = n_dir;
    assign o_next.pwr = n_pwr;

    `TLDC_ASSERT_NOW(a_pwr_matches_dir, i_clk, i_rst_n, 1'b1, r_pwr == (r_dir != DIR_STOP))
    `TLDC_ASSERT_NEXT(a_done_tick_stops, i_clk, i_rst_n, done_tick, drive_off)
    `TLDC_ASSERT_NEXT(a_cmd_keeps_drive, i_clk, i_rst_n, cmd_fire, cur_drive == $past(cur_drive))
    `TLDC_ASSERT_NOW(a_tick_push_active, i_clk, i_rst_n, o_push && tick_fire, r_cmd != ACT_DONE)

endmodule

`default_nettype wire

>>> design/tilt_limited_drive_controller.sv
// tilt limited drive controller
// input channel: i_in_valid / o_in_stall carry one transaction per item (kind,
// raw tilt sample, command code). output channel: o_out_valid / i_out_stall
// return exactly one result per item: smoothed tilt, drive direction, drive
// power and the active command after that item.
// the filter keeps a running total over a shift line of pre-divided samples,
// so each pushed sample is absorbed by one update of the total.
// an item goes from the input register to the result register, one item per
// cycle while i_out_stall is low. limits are to be written through i_cfg_we /
// i_cfg_index / i_cfg_data only while idle; the block does not enforce this.
// reset (synchronous, active low) clears the filter history and total, sets
// the command to done, the motor to stop with power off, and restores the
// default open and close limits. both channel stages come up empty.
// when the receiver stalls, the result register holds; one more transaction
// is taken into the input register, after which o_in_stall rises until the
// result is taken.
`default_nettype none

module tilt_limited_drive_controller
    import tldc_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_item          i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_item              o_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [TILT_W-1:0] i_cfg_data
);

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic in_load;
    logic out_load;
    logic push;
    logic signed [TILT_W-1:0] total;
    t_drive drive_next;

    assign out_load   = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !out_load;
    assign in_load    = i_in_valid && !o_in_stall;

    tldc_filter #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_sample(r_s1_item.tilt_sample),
        .o_total (total)
    );

    tldc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (out_load),
        .i_item     (r_s1_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_total    (total),
        .o_push     (push),
        .o_next     (drive_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_load) begin
            r_s1_valid <= 1'b1;
        end else if (out_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_s1_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item.smoothed_tilt   <= total;
            r_out_item.drive_direction <= drive_next.dir;
            r_out_item.drive_power     <= drive_next.pwr;
            r_out_item.current_command <= drive_next.cmd;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

`default_nettype wire

>>> tb/tilt_limited_drive_controller_test.sv
`timescale 1ns / 100ps

module tilt_limited_drive_controller_test;
    import tldc_pkg::*;

    logic              i_clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    t_in_item          in_data   = '0;
    logic              out_stall = 1'b0;
    logic              cfg_we    = 1'b0;
    logic              cfg_index = CFG_OPEN_LIMIT;
    logic [TILT_W-1:0] cfg_data  = '0;
    wire               in_stall;
    wire               out_valid;
    t_out_item         out_data;

    // predictor state
    logic signed [TILT_W-1:0] tilt_hist [WINDOW_DEPTH_DEF];
    logic signed [TILT_W-1:0] tilt_total;
    logic signed [TILT_W-1:0] open_lim;
    logic signed [TILT_W-1:0] close_lim;
    t_cmd                     cmd_now;
    t_dir                     dir_now;
    logic                     pwr_now;

    t_out_item pending_outcomes [$];
    int        mismatch_count = 0;
    int        idle_pct       = 0;
    int        stall_pct      = 0;

    tilt_limited_drive_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic void clear_predictor();
        for (int k = 0; k < WINDOW_DEPTH_DEF; k++) begin
            tilt_hist[k] = '0;
        end
        tilt_total = '0;
        open_lim   = OPEN_LIMIT_RST;
        close_lim  = CLOSE_LIMIT_RST;
        cmd_now    = ACT_DONE;
        dir_now    = DIR_STOP;
        pwr_now    = 1'b0;
    endfunction

    function automatic void shift_tilt(input int neg_tilt);
        int sum;
        sum = int'(tilt_total) - int'(tilt_hist[WINDOW_DEPTH_DEF-1]) / WINDOW_DEPTH_DEF;
        for (int k = WINDOW_DEPTH_DEF - 1; k > 0; k--) begin
            tilt_hist[k] = tilt_hist[k-1];
        end
        tilt_hist[0] = TILT_W'(neg_tilt);
        sum          = sum + neg_tilt / WINDOW_DEPTH_DEF;
        tilt_total   = TILT_W'(sum);
    endfunction

    function automatic t_out_item drive_outcome(input t_in_item it);
        int        neg_tilt;
        t_out_item res;
        neg_tilt = -int'(it.tilt_sample);
        case (it.kind)
            KIND_PRELOAD: begin
                shift_tilt(neg_tilt);
            end
            KIND_TICK: begin
                if (cmd_now == ACT_OPEN) begin
                    shift_tilt(neg_tilt);
                    if (tilt_total > open_lim) begin
                        dir_now = DIR_OPEN;
                        pwr_now = 1'b1;
                    end else begin
                        cmd_now = ACT_DONE;
                    end
                end else if (cmd_now == ACT_CLOSE) begin
                    shift_tilt(neg_tilt);
                    if (tilt_total < close_lim) begin
                        dir_now = DIR_CLOSE;
                        pwr_now = 1'b1;
                    end else begin
                        cmd_now = ACT_DONE;
                    end
                end else begin
                    dir_now = DIR_STOP;
                    pwr_now = 1'b0;
                end
            end
            KIND_COMMAND: begin
                if (it.command_code <= ACT_CLOSE) begin
                    cmd_now = t_cmd'(it.command_code);
                end
            end
            default: begin
            end
        endcase
        res.smoothed_tilt   = tilt_total;
        res.drive_direction = dir_now;
        res.drive_power     = pwr_now;
        res.current_command = cmd_now;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t ns: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("result with no transaction pending", 1, 0);
            end else begin
                want = pending_outcomes.pop_front();
                if (out_data.smoothed_tilt !== want.smoothed_tilt) begin
                    report_mismatch("smoothed_tilt", int'(out_data.smoothed_tilt),
                                    int'(want.smoothed_tilt));
                end
                if (out_data.drive_direction !== want.drive_direction) begin
                    report_mismatch("drive_direction", out_data.drive_direction,
                                    want.drive_direction);
                end
                if (out_data.drive_power !== want.drive_power) begin
                    report_mismatch("drive_power", out_data.drive_power, want.drive_power);
                end
                if (out_data.current_command !== want.current_command) begin
                    report_mismatch("current_command", out_data.current_command,
                                    want.current_command);
                end
            end
        end
    end

    function automatic t_in_item make_item(input logic [1:0] kind, input int sample,
                                           input logic [1:0] code);
        t_in_item it;
        it.kind         = kind;
        it.tilt_sample  = SAMPLE_W'(sample);
        it.command_code = code;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (in_stall);
        pending_outcomes.push_back(drive_outcome(it));
    endtask

    // hold the sender off until every result is back, then let the pipeline settle
    task automatic quiesce();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_limits(input int open_val, input int close_val);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_OPEN_LIMIT;
        cfg_data  <= TILT_W'(open_val);
        @(posedge i_clk);
        cfg_index <= CFG_CLOSE_LIMIT;
        cfg_data  <= TILT_W'(close_val);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        open_lim  = TILT_W'(open_val);
        close_lim = TILT_W'(close_val);
    endtask

    // bursts around a tilt level picked anew per burst so open and close runs last a while
    task automatic run_random_traffic(input int n_items);
        t_in_item it;
        int       level;
        int       burst_left;
        int       pick;
        int       sample;
        burst_left = 0;
        level      = 0;
        for (int n = 0; n < n_items; n++) begin
            if (burst_left == 0) begin
                level      = int'($urandom_range(4095)) - 2048;
                burst_left = $urandom_range(40, 4);
            end
            burst_left--;
            sample = level + int'($urandom_range(128)) - 64;
            if (sample > 2047) sample = 2047;
            if (sample < -2048) sample = -2048;
            if ($urandom_range(9) == 0) begin
                sample = int'($urandom_range(4095)) - 2048;
            end
            pick = $urandom_range(99);
            if (pick < 5) begin
                it = t_in_item'($urandom);
            end else if (pick < 25) begin
                it = make_item(KIND_PRELOAD, sample, 2'($urandom));
            end else if (pick < 80) begin
                it = make_item(KIND_TICK, sample, 2'($urandom));
            end else begin
                pick = $urandom_range(99);
                it = make_item(KIND_COMMAND, sample,
                               pick < 45 ? ACT_OPEN : (pick < 90 ? ACT_CLOSE : ACT_DONE));
            end
            send_item(it);
        end
    endtask

    task automatic test_directed_cases();
        send_item(make_item(KIND_TICK, 100, ACT_DONE));
        send_item('1);
        send_item(make_item(KIND_PRELOAD, -2048, ACT_DONE));
        send_item(make_item(KIND_PRELOAD, 2047, ACT_DONE));
        send_item(make_item(KIND_PRELOAD, 0, ACT_OPEN));
        send_item(make_item(KIND_PRELOAD, -1, ACT_CLOSE));
        send_item(make_item(KIND_PRELOAD, 17, ACT_DONE));
        send_item(make_item(KIND_PRELOAD, -17, ACT_DONE));
        send_item(make_item(KIND_PRELOAD, 16, ACT_DONE));
        send_item(make_item(KIND_PRELOAD, -16, ACT_DONE));
        send_item(make_item(KIND_COMMAND, 0, '1));
        send_item(make_item(KIND_COMMAND, 0, ACT_OPEN));
        send_item(make_item(KIND_TICK, -2048, ACT_DONE));
        send_item(make_item(KIND_TICK, -2048, ACT_DONE));
        send_item(make_item(KIND_COMMAND, 2047, ACT_CLOSE));
        send_item(make_item(KIND_TICK, -2048, ACT_DONE));
        send_item(make_item(KIND_TICK, -2048, ACT_DONE));
        send_item(make_item(KIND_TICK, 2047, ACT_DONE));
        send_item(make_item(KIND_COMMAND, 0, ACT_DONE));
        send_item(make_item(KIND_TICK, 0, ACT_DONE));
        send_item(make_item(KIND_COMMAND, -2048, ACT_OPEN));
        send_item(make_item(KIND_TICK, 2047, ACT_DONE));
    endtask

    task automatic test_limit_extremes();
        write_limits(-2048, 2048);
        run_random_traffic(100);
        write_limits(2048, -2048);
        run_random_traffic(100);
        write_limits(0, 0);
        run_random_traffic(50);
    endtask

    task automatic test_idle_phases();
        int idle_set  [4] = '{0, 67, 0, 25};
        int stall_set [4] = '{0, 0, 67, 25};
        for (int p = 0; p < 4; p++) begin
            write_limits(int'($urandom_range(4096)) - 2048, int'($urandom_range(4096)) - 2048);
            idle_pct  = idle_set[p];
            stall_pct = stall_set[p];
            run_random_traffic(130);
        end
    endtask

    task automatic test_drain_pause();
        idle_pct  = 25;
        stall_pct = 25;
        run_random_traffic(40);
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        run_random_traffic(40);
    endtask

    initial begin
        clear_predictor();
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_limit_extremes();
        test_idle_phases();
        test_drain_pause();
        stall_pct = 0;
        quiesce();
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
